>>> rtl/core/sscd_pkg.sv
// Shared types, codes and helper functions of the serial servo command decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sscd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_DIGITS  = 4;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SERVO   = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_START   = 3'd3;
  localparam logic [2:0] KIND_REVERSE = 3'd4;
  localparam logic [2:0] KIND_SPEED   = 3'd5;
  localparam logic [2:0] KIND_HOME    = 3'd6;

  localparam logic [2:0] CHAN_C = 3'd2;
  localparam logic [2:0] CHAN_F = 3'd5;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_L     = 8'h4c;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [15:0] ASCII_ZERO = 16'd48;

  localparam logic [15:0] SPEED_RESET = 16'd1600;

  // Classified item handed from the front to the back. digit[0] is the byte
  // right after the command letter.
  typedef struct packed {
    logic [2:0]                  kind;
    logic [2:0]                  chan;
    logic [NUM_DIGITS-1:0][7:0]  digit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic        enable;
    logic        direction;
    logic        led;
    logic [15:0] speed;
  } levels_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] chan;
    logic [7:0] compare;
    levels_t    lvl;
  } meta_t;

  // Quotient by ten through a reciprocal multiply; exact for all 16-bit inputs.
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = x * 32'd52429;
    return {3'b000, p[31:19]};
  endfunction

  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
    logic [15:0] r;
    r = x - q * 16'd10;
    return r[3:0];
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h27;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/sscd_front.sv
// Front part: line buffer, byte counter, line-end detection and command
// classification. Depends on sscd_pkg.
module sscd_front import sscd_pkg::*; #(
  parameter int LINE_LENGTH = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output cmd_t       cmd
);

  localparam int CNT_W = $clog2(LINE_LENGTH);

  logic [7:0]       line_buffer [LINE_LENGTH];
  logic [CNT_W-1:0] byte_count;
  logic             line_end;
  logic [7:0]       cur [NUM_DIGITS+1];

  assign line_end = (rx_byte == CHAR_SLASH) || (byte_count == CNT_W'(LINE_LENGTH - 1));

  // The line as it stands once the incoming byte is stored.
  always_comb begin
    for (int i = 0; i <= NUM_DIGITS; i++) begin
      cur[i] = (byte_count == CNT_W'(i)) ? rx_byte : line_buffer[i];
    end
  end

  always_comb begin
    cmd.kind = KIND_NONE;
    cmd.chan = 3'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      cmd.digit[i] = cur[i+1];
    end
    if (line_end) begin
      priority if (cur[0] >= CHAR_A && cur[0] <= CHAR_F) begin
        cmd.kind = KIND_SERVO;
        cmd.chan = 3'(cur[0] - CHAR_A);
      end else if (cur[0] == CHAR_R) begin
        cmd.kind = KIND_STOP;
      end else if (cur[0] == CHAR_S) begin
        cmd.kind = KIND_START;
      end else if (cur[0] == CHAR_L) begin
        cmd.kind = KIND_REVERSE;
      end else if (cur[0] == CHAR_V) begin
        cmd.kind = KIND_SPEED;
      end else if (cur[0] == CHAR_H) begin
        cmd.kind = KIND_HOME;
      end else begin
        cmd.kind = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < LINE_LENGTH; i++) begin
        line_buffer[i] <= 8'h00;
      end
    end else if (accept) begin
      line_buffer[byte_count] <= rx_byte;
      byte_count <= line_end ? '0 : byte_count + 1'b1;
    end
  end

endmodule

>>> rtl/core/sscd_queue.sv
// Short queue of classified items between the front and the back part.
// Depends on sscd_pkg.
module sscd_queue import sscd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_data,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign head         = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (PTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("push into a full queue");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == (PTR_W+1)'(1)) |=> status.empty)
    else $error("queue not empty after last item left");

endmodule

>>> rtl/core/sscd_back.sv
// Back part: executes classified items, holds the motor, LED and speed state,
// and converts the servo angle to segment codes in a five-stage pipeline.
// Depends on sscd_pkg.
module sscd_back import sscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  q_status_t   status,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser
);

  logic enable_level;
  logic direction_level;
  logic led_level;
  logic [15:0] speed_setting;

  logic        advance;
  logic [15:0] d [NUM_DIGITS];
  logic [15:0] ang;
  logic [15:0] speed_calc;
  logic [7:0]  cmp_calc;
  levels_t     lvl_next;

  // Stage registers.
  logic        v1, v2, v3, v4;
  meta_t       meta1, meta2, meta3, meta4;
  logic [15:0] ang1;
  logic [15:0] quo2, quo3, quo4;
  logic [3:0]  ones2, ones3, ones4;
  logic [3:0]  tens3, tens4;
  logic [3:0]  hund4;
  meta_t       meta5;
  logic [6:0]  seg3_q, seg2_q, seg1_q, seg0_q;
  logic        servo4;

  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && !status.empty;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d[i] = {8'h00, head.digit[i]} - ASCII_ZERO;
    end
    ang        = d[0] * 16'd100 + d[1] * 16'd10 + d[2];
    speed_calc = d[0] * 16'd1000 + d[1] * 16'd100 + d[2] * 16'd10 + d[3];
    if (head.kind != KIND_SERVO) begin
      cmp_calc = 8'h00;
    end else if (head.chan == CHAN_C) begin
      cmp_calc = 8'd210 - ang[7:0];
    end else if (head.chan == CHAN_F) begin
      cmp_calc = ang[7:0] + 8'd100;
    end else begin
      cmp_calc = 8'd230 - ang[7:0];
    end
  end

  always_comb begin
    lvl_next.enable    = enable_level;
    lvl_next.direction = direction_level;
    lvl_next.led       = led_level;
    lvl_next.speed     = speed_setting;
    unique case (head.kind)
      KIND_STOP: begin
        lvl_next.led       = 1'b0;
        lvl_next.enable    = 1'b0;
        lvl_next.direction = 1'b1;
      end
      KIND_START: begin
        lvl_next.led    = 1'b1;
        lvl_next.enable = 1'b1;
      end
      KIND_REVERSE: begin
        lvl_next.enable    = 1'b0;
        lvl_next.direction = 1'b0;
      end
      KIND_SPEED: begin
        lvl_next.speed = speed_calc;
      end
      KIND_HOME: begin
        lvl_next.enable    = 1'b1;
        lvl_next.direction = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_level    <= 1'b1;
      direction_level <= 1'b1;
      led_level       <= 1'b0;
      speed_setting   <= SPEED_RESET;
    end else if (pop) begin
      enable_level    <= lvl_next.enable;
      direction_level <= lvl_next.direction;
      led_level       <= lvl_next.led;
      speed_setting   <= lvl_next.speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      v1       <= pop;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4;
    end
  end

  // Payload stages: each after the first peels a decimal digit off the angle.
  always_ff @(posedge clk) begin
    if (advance) begin
      meta1.kind    <= head.kind;
      meta1.chan    <= head.chan;
      meta1.compare <= cmp_calc;
      meta1.lvl     <= lvl_next;
      ang1          <= ang;

      meta2 <= meta1;
      quo2  <= div10(ang1);
      ones2 <= rem10(ang1, div10(ang1));

      meta3 <= meta2;
      quo3  <= div10(quo2);
      tens3 <= rem10(quo2, div10(quo2));
      ones3 <= ones2;

      meta4 <= meta3;
      quo4  <= div10(quo3);
      hund4 <= rem10(quo3, div10(quo3));
      tens4 <= tens3;
      ones4 <= ones3;

      meta5  <= meta4;
      seg3_q <= servo4 ? seg_of(rem10(quo4, div10(quo4))) : 7'h00;
      seg2_q <= servo4 ? seg_of(hund4) : 7'h00;
      seg1_q <= servo4 ? seg_of(tens4) : 7'h00;
      seg0_q <= servo4 ? seg_of(ones4) : 7'h00;
    end
  end

  assign servo4 = (meta4.kind == KIND_SERVO);

  assign m_tuser = meta5.kind;
  assign m_tdata = {6'b000000, meta5.lvl.speed, meta5.lvl.led, meta5.lvl.direction,
                    meta5.lvl.enable, seg0_q, seg1_q, seg2_q, seg3_q,
                    meta5.compare, meta5.chan};

  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("popped item did not enter the pipeline");

  a_non_servo_clear: assert property (@(posedge clk) disable iff (rst)
    (v1 && meta1.kind != KIND_SERVO) |-> (meta1.chan == 3'd0 && meta1.compare == 8'h00))
    else $error("channel or compare set for a non-servo item");

  a_stop_levels: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_STOP) |=> (!enable_level && !led_level && direction_level))
    else $error("stop command did not set the levels");

endmodule

>>> rtl/core/serial_servo_command_decoder.sv
// Top level of the serial servo command decoder: front, queue and back part.
// Depends on sscd_pkg, sscd_front, sscd_queue and sscd_back.
//
//   Channel   Direction  Signals                      Payload
//   input     in         s_tvalid s_tready s_tdata    rx_byte
//   output    out        m_tvalid m_tready m_tdata    decoded result, kind on m_tuser
//
// One item is accepted per cycle while the queue is not full; every input byte
// gives exactly one result. The queue entry written at the accepting edge is
// popped into the first of the back pipeline's five register stages, and the
// last stage drives the output. The stage count is set by the angle computation
// and the four divide-by-ten steps of the angle-to-decimal conversion.
// Reset clears the line buffer and sets enable and direction high, LED low
// and speed to 1600. A stalled output holds the back pipeline; the front keeps
// accepting until the four-entry queue is full.
module serial_servo_command_decoder import sscd_pkg::*; #(
  parameter int LINE_LENGTH = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] servo_channel, [10:3] servo_compare, [17:11] seg_thousands,
  // [24:18] seg_hundreds, [31:25] seg_tens, [38:32] seg_ones, [39] motor_enable,
  // [40] motor_direction, [41] status_led, [57:42] speed_value, [63:58] zero
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser    // [2:0] command_kind
);

  logic      accept;
  logic      pop;
  cmd_t      front_cmd;
  cmd_t      head;
  q_status_t status;

  assign s_tready = !status.full;
  assign accept   = s_tvalid && s_tready;

  sscd_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .cmd     (front_cmd)
  );

  sscd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  sscd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .status   (status),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
